// ----- sv/cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared constants, register codes and control types of the cubic B-spline
// basis evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbb_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_MAX_NODES = 255;

    localparam int NODE_W      = 8;
    localparam int INDEX_W     = 9;
    localparam int NP1_W       = NODE_W + 1;
    localparam int K_W         = NP1_W + 1;
    localparam int POINT_INT_W = 4;
    localparam int OUT_INT_W   = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = INDEX_W;
    localparam int PIPE_LAT    = 8;

    localparam logic [NODE_W-1:0]  NODE_RESET  = NODE_W'(8);
    localparam logic [INDEX_W-1:0] INDEX_RESET = '0;

    localparam logic signed [K_W-1:0] K_ZERO = '0;
    localparam logic signed [K_W-1:0] K_ONE  = K_W'(1);
    localparam logic signed [K_W-1:0] K_NEG1 = '1;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_INDEX = 1'b1;

    typedef enum logic [1:0] {
        COEF_NONE = 2'd0,
        COEF_ONE  = 2'd1,
        COEF_FOUR = 2'd2
    } t_coef;

    typedef struct packed {
        logic  vld;
        logic  mode;
        logic  inv;
        t_coef coef;
    } t_ctl;

endpackage

`default_nettype wire

// ----- sv/cbb_spline.sv -----
// ----------------------------------------------------------------------------
// cbb_spline
// Four-stage evaluation of four times the cubic B-spline or its slope at
// y = t - k: segment selection, squares, cubes and final combination.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_spline import cbb_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int T_W  = FRAC_BITS + POINT_INT_W + 1 + K_W,
    localparam int S_W  = FRAC_BITS + 6
) (
    input  logic                  i_clk,
    input  logic signed [T_W-1:0] i_t,
    input  logic signed [K_W-1:0] i_k,
    input  logic                  i_mode,
    output logic signed [S_W-1:0] o_s4
);

    localparam int Y_W  = T_W + 1;
    localparam int U_W  = FRAC_BITS + 2;
    localparam int SQ_W = FRAC_BITS + 3;
    localparam int CU_W = FRAC_BITS + 4;
    localparam int P2_W = 2 * U_W;
    localparam int P3_W = SQ_W + U_W;

    localparam logic signed [Y_W-1:0] ONE  = Y_W'(1) << FRAC_BITS;
    localparam logic signed [Y_W-1:0] TWO  = Y_W'(2) << FRAC_BITS;
    localparam logic signed [Y_W-1:0] ZERO = '0;
    localparam logic [P2_W-1:0] HALF2 = P2_W'(1) << (FRAC_BITS - 1);
    localparam logic [P3_W-1:0] HALF3 = P3_W'(1) << (FRAC_BITS - 1);

    logic signed [Y_W-1:0] ks;
    logic signed [Y_W-1:0] y;
    logic signed [Y_W-1:0] u_lo;
    logic signed [Y_W-1:0] v_lo;
    logic signed [Y_W-1:0] u_hi;
    logic signed [Y_W-1:0] v_hi;
    logic [U_W-1:0]        n_u;
    logic [U_W-1:0]        n_v;
    logic                  n_neg;

    logic [U_W-1:0]  r1_u;
    logic [U_W-1:0]  r1_v;
    logic            r1_neg;
    logic            r1_mode;

    logic [P2_W-1:0] pu;
    logic [P2_W-1:0] pv;
    logic [SQ_W-1:0] r2_sq_u;
    logic [SQ_W-1:0] r2_sq_v;
    logic [U_W-1:0]  r2_u;
    logic [U_W-1:0]  r2_v;
    logic            r2_neg;
    logic            r2_mode;

    logic [P3_W-1:0] cu;
    logic [P3_W-1:0] cv;
    logic [CU_W-1:0] r3_cu_u;
    logic [CU_W-1:0] r3_cu_v;
    logic [SQ_W-1:0] r3_sq_u;
    logic [SQ_W-1:0] r3_sq_v;
    logic            r3_neg;
    logic            r3_mode;

    logic signed [S_W-1:0] e_cu_u;
    logic signed [S_W-1:0] e_cu_v;
    logic signed [S_W-1:0] e_sq_u;
    logic signed [S_W-1:0] e_sq_v;
    logic signed [S_W-1:0] val;
    logic signed [S_W-1:0] dif;
    logic signed [S_W-1:0] dif3;
    logic signed [S_W-1:0] n_s4;

    assign ks   = {{(Y_W - K_W - FRAC_BITS){i_k[K_W-1]}}, i_k, {FRAC_BITS{1'b0}}};
    assign y    = {i_t[T_W-1], i_t} - ks;
    assign u_lo = TWO + y;
    assign v_lo = ONE + y;
    assign u_hi = TWO - y;
    assign v_hi = ONE - y;

    always_comb begin
        n_u   = '0;
        n_v   = '0;
        n_neg = 1'b0;
        if ((y > -TWO) && (y <= TWO)) begin
            if (y <= -ONE) begin
                n_u = u_lo[U_W-1:0];
            end else if (y <= ZERO) begin
                n_u = u_lo[U_W-1:0];
                n_v = v_lo[U_W-1:0];
            end else if (y <= ONE) begin
                n_u   = u_hi[U_W-1:0];
                n_v   = v_hi[U_W-1:0];
                n_neg = 1'b1;
            end else begin
                n_u   = u_hi[U_W-1:0];
                n_neg = 1'b1;
            end
        end
    end

    assign pu = P2_W'(r1_u) * P2_W'(r1_u) + HALF2;
    assign pv = P2_W'(r1_v) * P2_W'(r1_v) + HALF2;

    assign cu = P3_W'(r2_sq_u) * P3_W'(r2_u) + HALF3;
    assign cv = P3_W'(r2_sq_v) * P3_W'(r2_v) + HALF3;

    assign e_cu_u = {{(S_W - CU_W){1'b0}}, r3_cu_u};
    assign e_cu_v = {{(S_W - CU_W){1'b0}}, r3_cu_v};
    assign e_sq_u = {{(S_W - SQ_W){1'b0}}, r3_sq_u};
    assign e_sq_v = {{(S_W - SQ_W){1'b0}}, r3_sq_v};
    assign val    = e_cu_u - (e_cu_v <<< 2);
    assign dif    = e_sq_u - (e_sq_v <<< 2);
    assign dif3   = (dif <<< 1) + dif;

    always_comb begin
        if (r3_mode) begin
            n_s4 = r3_neg ? -dif3 : dif3;
        end else begin
            n_s4 = val;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u    <= n_u;
        r1_v    <= n_v;
        r1_neg  <= n_neg;
        r1_mode <= i_mode;

        r2_sq_u <= pu[FRAC_BITS +: SQ_W];
        r2_sq_v <= pv[FRAC_BITS +: SQ_W];
        r2_u    <= r1_u;
        r2_v    <= r1_v;
        r2_neg  <= r1_neg;
        r2_mode <= r1_mode;

        r3_cu_u <= cu[FRAC_BITS +: CU_W];
        r3_cu_v <= cv[FRAC_BITS +: CU_W];
        r3_sq_u <= r2_sq_u;
        r3_sq_v <= r2_sq_v;
        r3_neg  <= r2_neg;
        r3_mode <= r2_mode;

        o_s4    <= n_s4;
    end

endmodule

`default_nettype wire

// ----- sv/cbb_post.sv -----
// ----------------------------------------------------------------------------
// cbb_post
// Three-stage back end: combines the two splines, scales a derivative by
// n+1, then rounds, saturates and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_post import cbb_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int S_W   = FRAC_BITS + 6,
    localparam int OUT_W = FRAC_BITS + OUT_INT_W + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [NP1_W-1:0]        i_np1,
    input  logic signed [S_W-1:0]   i_s_a,
    input  logic signed [S_W-1:0]   i_s_b,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_result,
    output logic                    o_invalid
);

    localparam int ACC_W = S_W + 3;
    localparam int SC_W  = ACC_W + K_W;

    localparam logic signed [SC_W-1:0] RND  = SC_W'(2);
    localparam logic signed [SC_W-1:0] OMAX =
        {{(SC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [SC_W-1:0] OMIN =
        {{(SC_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    logic signed [ACC_W-1:0] e_a;
    logic signed [ACC_W-1:0] e_b;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [SC_W-1:0]  n_sc;
    logic signed [SC_W-1:0]  rsum;
    logic signed [SC_W-1:0]  rs;
    logic signed [OUT_W-1:0] n_res;

    t_ctl                    r_a_ctl;
    t_ctl                    r_b_ctl;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SC_W-1:0]  r_sc;

    assign e_a = {{(ACC_W - S_W){i_s_a[S_W-1]}}, i_s_a};
    assign e_b = {{(ACC_W - S_W){i_s_b[S_W-1]}}, i_s_b};

    always_comb begin
        case (i_ctl.coef)
            COEF_FOUR: n_acc = e_a - (e_b <<< 2);
            COEF_ONE:  n_acc = e_a - e_b;
            COEF_NONE: n_acc = e_a;
            default:   n_acc = e_a;
        endcase
    end

    always_comb begin
        if (r_a_ctl.mode) begin
            n_sc = SC_W'(r_acc) * SC_W'($signed({1'b0, i_np1}));
        end else begin
            n_sc = {{K_W{r_acc[ACC_W-1]}}, r_acc};
        end
    end

    assign rsum = r_sc + RND;
    assign rs   = rsum >>> 2;

    always_comb begin
        if (r_b_ctl.inv) begin
            n_res = '0;
        end else if (rs > OMAX) begin
            n_res = OMAX[OUT_W-1:0];
        end else if (rs < OMIN) begin
            n_res = OMIN[OUT_W-1:0];
        end else begin
            n_res = rs[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl   <= '0;
            r_b_ctl   <= '0;
            o_valid   <= 1'b0;
            o_invalid <= 1'b0;
        end else begin
            r_a_ctl   <= i_ctl;
            r_b_ctl   <= r_a_ctl;
            o_valid   <= r_b_ctl.vld;
            o_invalid <= r_b_ctl.inv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_sc     <= n_sc;
        o_result <= n_res;
    end

endmodule

`default_nettype wire

// ----- sv/cubic_bspline_basis_eval.sv -----
// ----------------------------------------------------------------------------
// cubic_bspline_basis_eval
// Boundary-adapted cubic B-spline basis evaluator, value or derivative,
// on a uniform grid of n+1 intervals.
//
// A transaction is taken at each rising edge where start is high and busy
// is low, with the point and the mode on i_point and i_mode. The result
// appears on o_result_value and o_index_invalid for one cycle, marked by
// o_valid. The block is fully pipelined and takes one transaction every
// cycle; the depth is set by the input multiply, the four stages of the
// spline unit (segment, square, cube, combine) and the three back-end
// stages (combine, scale, round).
// The configuration port writes node_count (index 0) and basis_index
// (index 1) at any edge where i_cfg_we is high; change them only while no
// transaction is in flight. Reset returns node_count to 8 and basis_index
// to 0, flushes the pipeline, and holds busy high until the first edge
// after reset is released. The receiver cannot stall, so no result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bspline_basis_eval import cbb_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int MAX_NODES = DEF_MAX_NODES,
    localparam int PT_W  = FRAC_BITS + POINT_INT_W + 1,
    localparam int OUT_W = FRAC_BITS + OUT_INT_W + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [PT_W-1:0]  i_point,
    input  logic                    i_mode,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_result_value,
    output logic                    o_index_invalid,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int T_W = PT_W + K_W;
    localparam int S_W = FRAC_BITS + 6;

    logic [NODE_W-1:0]  r_node_count;
    logic [INDEX_W-1:0] r_basis_index;
    logic               r_busy;

    logic [NODE_W-1:0]     n_eff;
    logic [NP1_W-1:0]      np1;
    logic signed [T_W-1:0] n_t;
    logic signed [K_W-1:0] n_ka;
    logic signed [K_W-1:0] n_kb;
    t_ctl                  n_ctl;

    logic signed [T_W-1:0] r_t;
    logic signed [K_W-1:0] r_ka;
    logic signed [K_W-1:0] r_kb;
    t_ctl                  r_ctl;
    t_ctl                  r_ctl_d [4];

    logic signed [S_W-1:0] s_a;
    logic signed [S_W-1:0] s_b;

    assign busy  = r_busy;
    assign n_eff = (32'(r_node_count) > MAX_NODES) ? NODE_W'(MAX_NODES) : r_node_count;
    assign np1   = {1'b0, n_eff} + NP1_W'(1);
    assign n_t   = T_W'(i_point) * T_W'($signed({1'b0, np1}));

    always_comb begin
        n_ctl.vld  = start && !r_busy;
        n_ctl.mode = i_mode;
        n_ctl.inv  = r_basis_index > np1;
        if (r_basis_index == INDEX_W'(0)) begin
            n_ka       = K_ZERO;
            n_kb       = K_NEG1;
            n_ctl.coef = COEF_FOUR;
        end else if (r_basis_index == INDEX_W'(1)) begin
            n_ka       = K_ONE;
            n_kb       = K_NEG1;
            n_ctl.coef = COEF_ONE;
        end else if (r_basis_index < {1'b0, n_eff}) begin
            n_ka       = {1'b0, r_basis_index};
            n_kb       = K_ZERO;
            n_ctl.coef = COEF_NONE;
        end else if (r_basis_index == {1'b0, n_eff}) begin
            n_ka       = {2'b00, n_eff};
            n_kb       = {1'b0, np1} + K_ONE;
            n_ctl.coef = COEF_ONE;
        end else begin
            n_ka       = {1'b0, np1};
            n_kb       = {1'b0, np1} + K_ONE;
            n_ctl.coef = COEF_FOUR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= NODE_RESET;
            r_basis_index <= INDEX_RESET;
            r_busy        <= 1'b1;
            r_ctl         <= '0;
            for (int k = 0; k < 4; k++) begin
                r_ctl_d[k] <= '0;
            end
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NODE_COUNT:  r_node_count  <= i_cfg_data[NODE_W-1:0];
                    REG_BASIS_INDEX: r_basis_index <= i_cfg_data[INDEX_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_ctl      <= n_ctl;
            r_ctl_d[0] <= r_ctl;
            for (int k = 1; k < 4; k++) begin
                r_ctl_d[k] <= r_ctl_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t  <= n_t;
        r_ka <= n_ka;
        r_kb <= n_kb;
    end

    cbb_spline #(.FRAC_BITS(FRAC_BITS)) u_spline_a (
        .i_clk  (i_clk),
        .i_t    (r_t),
        .i_k    (r_ka),
        .i_mode (r_ctl.mode),
        .o_s4   (s_a)
    );

    cbb_spline #(.FRAC_BITS(FRAC_BITS)) u_spline_b (
        .i_clk  (i_clk),
        .i_t    (r_t),
        .i_k    (r_kb),
        .i_mode (r_ctl.mode),
        .o_s4   (s_b)
    );

    cbb_post #(.FRAC_BITS(FRAC_BITS)) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_ctl_d[3]),
        .i_np1     (np1),
        .i_s_a     (s_a),
        .i_s_b     (s_b),
        .o_valid   (o_valid),
        .o_result  (o_result_value),
        .o_invalid (o_index_invalid)
    );

endmodule

`default_nettype wire

// ----- sv/cbb_checker.sv -----
// ----------------------------------------------------------------------------
// cbb_checker
// Port-level checks of the basis evaluator: fixed latency, zero result on
// an invalid index, reset behavior and continuous readiness.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_checker import cbb_pkg::*; #(
    parameter int OUT_W = DEF_FRAC_BITS + OUT_INT_W + 1
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic                    o_valid,
    input wire logic signed [OUT_W-1:0] o_result_value,
    input wire logic                    o_index_invalid
);

    logic [3:0] r_since_rst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_rst <= '0;
        end else if (r_since_rst < 4'(PIPE_LAT)) begin
            r_since_rst <= r_since_rst + 4'd1;
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_since_rst >= 4'(PIPE_LAT)) |-> (o_valid == $past(start && !busy, PIPE_LAT)))
        else $error("result strobe does not follow an accepted transaction");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_invalid) |-> (o_result_value == '0))
        else $error("invalid index produced a nonzero result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_valid))
        else $error("reset did not flush the pipeline");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy asserted outside reset");

endmodule

bind cubic_bspline_basis_eval cbb_checker #(.OUT_W(OUT_W)) u_cbb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_result_value  (o_result_value),
    .o_index_invalid (o_index_invalid)
);

`default_nettype wire

// ----- tb/tb_cubic_bspline_basis_eval.sv -----
// ----------------------------------------------------------------------------
// tb_cubic_bspline_basis_eval
// Self-checking testbench for the cubic B-spline basis evaluator. A directed
// table covers the reset setting, the field extremes, the segment boundaries
// of the spline, all index branches and invalid indexes. Random phases then
// sweep node counts and basis indexes under several idle patterns. Results
// are compared with a bit-accurate fixed-point predictor or typed table rows.
// ----------------------------------------------------------------------------
module tb_cubic_bspline_basis_eval import cbb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC    = DEF_FRAC_BITS;
    localparam int PT_W    = FRAC + POINT_INT_W + 1;
    localparam int OUT_W   = FRAC + OUT_INT_W + 1;
    localparam longint ONE = longint'(1) <<< FRAC;
    localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) <<< (OUT_W - 1));
    localparam logic MODE_VALUE = 1'b0;
    localparam logic MODE_DERIV = 1'b1;
    localparam int LIMIT       = 300000;
    localparam int DIR_N       = 26;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    invalid;
    } t_basis_result;

    typedef struct {
        int nodes;
        int index;
        int point;
        int mode;
        int typed;
        int value;
        int invalid;
    } t_vec_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [PT_W-1:0]  i_point;
    logic                    i_mode;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_result_value;
    logic                    o_index_invalid;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    logic          tag_typed;
    t_basis_result tag_result;

    t_basis_result pending_basis_q[$];
    int unsigned   cfg_nodes;
    int unsigned   cfg_index;
    int            errors;
    int            sent_count;
    int            checked_count;
    int            invalid_count;
    int            cfg_count;
    int            cycles;
    t_vec_row      dir_tab [DIR_N];

    cubic_bspline_basis_eval uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_point         (i_point),
        .i_mode          (i_mode),
        .o_valid         (o_valid),
        .o_result_value  (o_result_value),
        .o_index_invalid (o_index_invalid),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint fx_square(input longint u);
        return (u * u + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint fx_cube(input longint u);
        return (fx_square(u) * u + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // Four times the cardinal cubic spline, or four times its slope.
    function automatic longint spline_x4(input longint y, input logic deriv);
        if (y <= -2 * ONE || y > 2 * ONE)
            return 0;
        if (y <= -ONE)
            return deriv ? 3 * fx_square(2 * ONE + y) : fx_cube(2 * ONE + y);
        if (y <= 0)
            return deriv ? 3 * (fx_square(2 * ONE + y) - 4 * fx_square(ONE + y))
                         : fx_cube(2 * ONE + y) - 4 * fx_cube(ONE + y);
        if (y <= ONE)
            return deriv ? -3 * (fx_square(2 * ONE - y) - 4 * fx_square(ONE - y))
                         : fx_cube(2 * ONE - y) - 4 * fx_cube(ONE - y);
        return deriv ? -3 * fx_square(2 * ONE - y) : fx_cube(2 * ONE - y);
    endfunction

    function automatic t_basis_result eval_basis(input logic signed [PT_W-1:0] p,
                                                 input logic m,
                                                 input int unsigned nodes,
                                                 input int unsigned index);
        longint        x;
        longint        n;
        longint        i;
        longint        t;
        longint        acc;
        longint        res;
        t_basis_result r;
        x = p;
        n = nodes;
        i = index;
        if (n > DEF_MAX_NODES)
            n = DEF_MAX_NODES;
        r.invalid = 1'b0;
        if (i > n + 1) begin
            r.value   = '0;
            r.invalid = 1'b1;
            return r;
        end
        t = x * (n + 1);
        if (i == 0)
            acc = spline_x4(t, m) - 4 * spline_x4(t + ONE, m);
        else if (i == 1)
            acc = spline_x4(t - ONE, m) - spline_x4(t + ONE, m);
        else if (i <= n - 1)
            acc = spline_x4(t - i * ONE, m);
        else if (i == n)
            acc = spline_x4(t - n * ONE, m) - spline_x4(t - (n + 2) * ONE, m);
        else
            acc = spline_x4(t - (n + 1) * ONE, m) - 4 * spline_x4(t - (n + 2) * ONE, m);
        if (m == MODE_DERIV)
            acc = acc * (n + 1);
        res = (acc + 2) >>> 2;
        if (res > OUT_MAX)
            res = OUT_MAX;
        if (res < OUT_MIN)
            res = OUT_MIN;
        r.value = res[OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] error: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pending_basis_q.push_back(tag_typed ? tag_result
                : eval_basis(i_point, i_mode, cfg_nodes, cfg_index));
        end
    end

    always @(posedge i_clk) begin
        t_basis_result exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_basis_q.size() == 0) begin
                flag_error($sformatf("unexpected result value %0d invalid %0b",
                                     o_result_value, o_index_invalid));
            end else begin
                exp_r = pending_basis_q.pop_front();
                checked_count++;
                if (o_index_invalid)
                    invalid_count++;
                if (o_result_value !== exp_r.value || o_index_invalid !== exp_r.invalid)
                    flag_error($sformatf({"result mismatch: expected value %0d invalid %0b,",
                                          " got value %0d invalid %0b"},
                                         exp_r.value, exp_r.invalid,
                                         o_result_value, o_index_invalid));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic settle();
        start <= 1'b0;
        while (pending_basis_q.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] node_data,
                                input logic [CFG_DATA_W-1:0] index_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_NODE_COUNT;
        i_cfg_data <= node_data;
        @(negedge i_clk);
        i_cfg_idx  <= REG_BASIS_INDEX;
        i_cfg_data <= index_data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_nodes = node_data[NODE_W-1:0];
        cfg_index = index_data;
        cfg_count++;
    endtask

    task automatic send_point(input logic signed [PT_W-1:0] p, input logic m,
                              input int idle_pct, input logic typed,
                              input t_basis_result typed_r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_point    <= p;
        i_mode     <= m;
        tag_typed  <= typed;
        tag_result <= typed_r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    initial begin
        t_basis_result    tr;
        int               idle_pct;
        int unsigned      nodes;
        int unsigned      index;
        int unsigned      r;
        logic [CFG_DATA_W-1:0] node_data;
        logic signed [PT_W-1:0] p;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_point    = '0;
        i_mode     = MODE_VALUE;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_NODE_COUNT;
        i_cfg_data = '0;
        tag_typed  = 1'b0;
        tag_result = '0;
        cfg_nodes  = NODE_RESET;
        cfg_index  = INDEX_RESET;
        errors = 0;
        sent_count = 0;
        checked_count = 0;
        invalid_count = 0;
        cfg_count = 0;
        cycles = 0;

        dir_tab = '{
            '{8,   0,   0,        0, 1, 0, 0},
            '{8,   0,   0,        1, 0, 0, 0},
            '{8,   0,   1048575,  0, 1, 0, 0},
            '{8,   0,   -1048576, 1, 1, 0, 0},
            '{8,   1,   7282,     0, 0, 0, 0},
            '{8,   4,   29127,    1, 0, 0, 0},
            '{8,   8,   60000,    1, 0, 0, 0},
            '{8,   9,   65536,    0, 0, 0, 0},
            '{8,   9,   65535,    1, 0, 0, 0},
            '{8,   10,  0,        0, 1, 0, 1},
            '{3,   2,   0,        0, 0, 0, 0},
            '{3,   2,   16384,    1, 0, 0, 0},
            '{3,   2,   32768,    0, 0, 0, 0},
            '{3,   2,   49152,    1, 0, 0, 0},
            '{3,   2,   65536,    0, 0, 0, 0},
            '{3,   4,   -1048576, 0, 1, 0, 0},
            '{0,   0,   30000,    0, 0, 0, 0},
            '{0,   1,   -20000,   1, 0, 0, 0},
            '{0,   2,   0,        0, 1, 0, 1},
            '{1,   2,   40000,    1, 0, 0, 0},
            '{2,   2,   50000,    0, 0, 0, 0},
            '{255, 0,   100,      1, 0, 0, 0},
            '{255, 128, 32768,    0, 0, 0, 0},
            '{255, 256, 65536,    1, 0, 0, 0},
            '{255, 257, 0,        0, 1, 0, 1},
            '{255, 511, -1,       1, 1, 0, 1}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].nodes != cfg_nodes || dir_tab[k].index != cfg_index) begin
                settle();
                write_config(CFG_DATA_W'(dir_tab[k].nodes), CFG_DATA_W'(dir_tab[k].index));
            end
            tr.value   = OUT_W'(dir_tab[k].value);
            tr.invalid = dir_tab[k].invalid[0];
            send_point(PT_W'(dir_tab[k].point), dir_tab[k].mode[0], 0,
                       dir_tab[k].typed[0], tr);
        end

        tr = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 85 : 13;
            nodes = $urandom_range(1, 255);
            r = $urandom_range(99);
            if (r < 10)
                index = (nodes + 2 > 511) ? 511 : $urandom_range(nodes + 2, 511);
            else if (r < 50)
                case ($urandom_range(3))
                    0: index = 0;
                    1: index = 1;
                    2: index = nodes;
                    default: index = nodes + 1;
                endcase
            else
                index = $urandom_range(0, nodes + 1);
            case (ph)
                0: begin nodes = 1;   index = 2;   end
                1: begin nodes = 255; index = 256; end
                2: begin nodes = 0;   index = 1;   end
                3: begin nodes = 255; index = 511; end
                default: ;
            endcase
            node_data = {1'($urandom_range(1)), NODE_W'(nodes)};
            write_config(node_data, CFG_DATA_W'(index));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 20)
                    p = PT_W'($urandom);
                else
                    p = PT_W'(int'($urandom_range(0, ONE + ONE / 4)) - ONE / 8);
                send_point(p, 1'($urandom_range(1)), idle_pct, 1'b0, tr);
                if (ph == 4 && k == PHASE_ITEMS / 2)
                    settle();
            end
        end

        settle();
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (pending_basis_q.size() != 0)
            flag_error($sformatf("%0d expected results never arrived",
                                 pending_basis_q.size()));
        $display("Sent %0d points over %0d register settings; %0d results checked.",
                 sent_count, cfg_count, checked_count);
        $display("Invalid-index results: %0d; errors: %0d.", invalid_count, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
